// ----- hw/rtl/polyline_point_filter_direction_core_assert.svh -----
// ----------------------------------------------------------------------------
// Polyline point filter assertion macros
// Concurrent assertion wrappers. They compile to nothing under synthesis.
// ----------------------------------------------------------------------------
`ifndef POLYLINE_POINT_FILTER_DIRECTION_CORE_ASSERT_SVH
`define POLYLINE_POINT_FILTER_DIRECTION_CORE_ASSERT_SVH

`ifndef SYNTHESIS
// Check on every clock edge outside of reset.
`define PPFD_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error("ppfd: assertion failed");
// Check on every clock edge, reset included.
`define PPFD_ASSERT_ALWAYS(lbl, prop) \
    lbl: assert property (@(posedge i_clk) prop) \
        else $error("ppfd: assertion failed");
`else
`define PPFD_ASSERT(lbl, prop)
`define PPFD_ASSERT_ALWAYS(lbl, prop)
`endif

`endif

// ----- hw/rtl/ppfd_pkg.sv -----
// ----------------------------------------------------------------------------
// Polyline point filter package
// Field widths, register indexes and shared types.
// ----------------------------------------------------------------------------
package ppfd_pkg;

    localparam int CoordW  = 32;
    localparam int LimitW  = 31;
    localparam int DirW    = 16;
    localparam int LabelW  = 8;
    localparam int CfgIdxW = 2;
    localparam int Axes    = 3;

    localparam int InDataW  = Axes * CoordW;
    localparam int InUserW  = 1 + LabelW;
    localparam int OutDataW = Axes * CoordW + Axes * DirW;
    localparam int OutUserW = LabelW;

    // Configuration register indexes
    localparam logic [CfgIdxW-1:0] CfgCenterX  = 2'd0;
    localparam logic [CfgIdxW-1:0] CfgCenterY  = 2'd1;
    localparam logic [CfgIdxW-1:0] CfgCenterZ  = 2'd2;
    localparam logic [CfgIdxW-1:0] CfgDistLimit = 2'd3;

    typedef logic signed [CoordW-1:0] t_coord;
    typedef logic signed [DirW-1:0]   t_dir;

endpackage

// ----- hw/rtl/polyline_point_filter_direction_core.sv -----
// ----------------------------------------------------------------------------
// Polyline point filter with segment direction
// Keeps polyline vertices near a configured centre and tags each with the
// unit direction of the segment that leads into it.
// ----------------------------------------------------------------------------
// Vertices stream in one transaction at a time. Each is tested against the
// sphere of radius distance_limit around (center_x, center_y, center_z) by
// comparing the squared distance with the squared limit; a vertex outside
// is dropped and a vertex inside yields one result transaction carrying the
// coordinates, the label and the Q1.DIR_FRAC_BITS unit vector from the
// previous vertex (zero at a line start or on a zero-length segment). The
// previous vertex is remembered for every vertex, kept or not. One item is
// processed at a time and o_s_tready stays low while it is at work. All
// arithmetic runs on one shared 32x32 squarer plus a one-bit-per-cycle
// square root and divider. A dropped vertex returns to idle after the
// distance test, a kept first vertex goes straight on to the output, and
// any other kept vertex first passes the square root and then, unless its
// segment has zero length, the three component divisions. A finished
// result waits in an output register, so the next vertex is taken while
// it is still unread. Configuration writes are always accepted; write
// them only while the block is idle.

`include "polyline_point_filter_direction_core_assert.svh"

module polyline_point_filter_direction_core #(
    parameter int DIR_FRAC_BITS = 15
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // Configuration write channel
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [ppfd_pkg::CfgIdxW-1:0]  i_cfg_index,
    input  logic [31:0]                   i_cfg_data,
    // Vertex input stream
    input  logic                          i_s_tvalid,
    output logic                          o_s_tready,
    input  logic [ppfd_pkg::InDataW-1:0]  i_s_tdata,  // point_x, point_y, point_z
    input  logic [ppfd_pkg::InUserW-1:0]  i_s_tuser,  // line_start, label
    // Result output stream
    output logic                          o_m_tvalid,
    input  logic                          i_m_tready,
    output logic [ppfd_pkg::OutDataW-1:0] o_m_tdata,  // out_x, out_y, out_z, dir_x, dir_y, dir_z
    output logic [ppfd_pkg::OutUserW-1:0] o_m_tuser   // out_label
);

    localparam int QW   = DIR_FRAC_BITS + 1;   // quotient never exceeds 2^DIR_FRAC_BITS
    localparam int CntW = $clog2(DIR_FRAC_BITS + 1);

    localparam logic [32:0] PosMax = 33'd32767;
    localparam logic [32:0] NegMax = 33'd32768;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DIST,
        S_NORM,
        S_SQRT,
        S_DIV,
        S_EMIT
    } t_state;

    t_state r_state;

    // Configuration
    ppfd_pkg::t_coord            r_ctr [ppfd_pkg::Axes];
    logic [ppfd_pkg::LimitW-1:0] r_lim;

    // Previous vertex
    ppfd_pkg::t_coord r_prev [ppfd_pkg::Axes];

    // Item being processed
    ppfd_pkg::t_coord            r_pt   [ppfd_pkg::Axes];
    logic [31:0]                 r_cmag [ppfd_pkg::Axes];   // |vertex - centre|
    logic [30:0]                 r_mag  [ppfd_pkg::Axes];   // |segment|, scaled
    logic                        r_neg  [ppfd_pkg::Axes];   // segment component < 0
    logic                        r_first;
    logic [ppfd_pkg::LabelW-1:0] r_label;

    // Shared arithmetic state
    logic [CntW-1:0]             r_cnt;
    logic [1:0]                  r_axis;
    logic [63:0]                 r_prod;
    logic [65:0]                 r_acc;
    logic [63:0]                 r_v;
    logic [63:0]                 r_root;
    logic [63:0]                 r_bit;
    logic [31:0]                 r_norm;
    logic [31:0]                 r_rem;
    logic [QW-2:0]               r_q;
    ppfd_pkg::t_dir              r_dir [ppfd_pkg::Axes];

    // Output register
    logic                           r_out_valid;
    logic [ppfd_pkg::OutDataW-1:0]  r_out_data;
    logic [ppfd_pkg::OutUserW-1:0]  r_out_user;

    // Accept-time helpers
    ppfd_pkg::t_coord in_pt   [ppfd_pkg::Axes];
    logic [31:0]      in_cmag [ppfd_pkg::Axes];
    logic [31:0]      in_dmag [ppfd_pkg::Axes];
    logic             in_dneg [ppfd_pkg::Axes];
    logic             in_shift;
    logic [32:0]      cdiff;
    logic [32:0]      ddiff;
    logic [32:0]      cneg;
    logic [32:0]      dneg;

    logic             in_accept;
    logic             out_free;

    // Shared squarer
    logic [31:0]      sq_op;
    logic [63:0]      sq_res;

    // Square root step
    logic [64:0]      sqrt_sum;
    logic             sqrt_ge;
    logic [63:0]      n_root;

    // Divider step
    logic [32:0]      div_trial;
    logic             div_ge;
    logic [31:0]      n_rem;
    logic [QW-1:0]    n_q;
    logic [32:0]      q_ext;
    ppfd_pkg::t_dir   n_dir;

    assign in_accept  = i_s_tvalid && o_s_tready;
    assign out_free   = !r_out_valid || i_m_tready;

    assign o_cfg_ready = 1'b1;
    assign o_s_tready  = (r_state == S_IDLE);
    assign o_m_tvalid  = r_out_valid;
    assign o_m_tdata   = r_out_data;
    assign o_m_tuser   = r_out_user;

    // Distance to centre and segment from previous vertex, per axis
    always_comb begin
        cdiff = '0;
        ddiff = '0;
        cneg  = '0;
        dneg  = '0;
        for (int i = 0; i < ppfd_pkg::Axes; i++) begin
            in_pt[i]   = i_s_tdata[ppfd_pkg::CoordW*i +: ppfd_pkg::CoordW];
            cdiff      = {in_pt[i][31], in_pt[i]} - {r_ctr[i][31], r_ctr[i]};
            ddiff      = {in_pt[i][31], in_pt[i]} - {r_prev[i][31], r_prev[i]};
            cneg       = 33'd0 - cdiff;
            dneg       = 33'd0 - ddiff;
            in_cmag[i] = cdiff[32] ? cneg[31:0] : cdiff[31:0];
            in_dmag[i] = ddiff[32] ? dneg[31:0] : ddiff[31:0];
            in_dneg[i] = ddiff[32];
        end
        in_shift = in_dmag[0][31] || in_dmag[1][31] || in_dmag[2][31];
    end

    // Squarer operand: distance terms, limit, then segment terms
    always_comb begin
        sq_op = '0;
        case (r_state)
            S_DIST: begin
                case (r_cnt)
                    CntW'(0): sq_op = r_cmag[0];
                    CntW'(1): sq_op = r_cmag[1];
                    CntW'(2): sq_op = r_cmag[2];
                    default:  sq_op = {1'b0, r_lim};
                endcase
            end
            S_NORM: begin
                case (r_cnt)
                    CntW'(0): sq_op = {1'b0, r_mag[0]};
                    CntW'(1): sq_op = {1'b0, r_mag[1]};
                    default:  sq_op = {1'b0, r_mag[2]};
                endcase
            end
            default: sq_op = '0;
        endcase
    end

    assign sq_res = sq_op * sq_op;

    // Bit-pair square root step
    assign sqrt_sum = {1'b0, r_root} + {1'b0, r_bit};
    assign sqrt_ge  = {1'b0, r_v} >= sqrt_sum;
    assign n_root   = sqrt_ge ? ((r_root >> 1) + r_bit) : (r_root >> 1);

    // Restoring division step; first step takes the integer bit unshifted
    always_comb begin
        div_trial = (r_cnt == '0) ? {1'b0, r_rem} : {r_rem, 1'b0};
        div_ge    = div_trial >= {1'b0, r_norm};
        n_rem     = div_ge ? 32'(div_trial - {1'b0, r_norm}) : div_trial[31:0];
        n_q       = {r_q, div_ge};
        q_ext     = 33'(n_q);
        if (r_neg[r_axis]) begin
            n_dir = (q_ext > NegMax) ? 16'sh8000 : 16'(33'd0 - q_ext);
        end else begin
            n_dir = (q_ext > PosMax) ? 16'sh7fff : 16'(q_ext);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_lim       <= '0;
            for (int i = 0; i < ppfd_pkg::Axes; i++) begin
                r_ctr[i]  <= '0;
                r_prev[i] <= '0;
            end
        end else begin
            // Configuration writes
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    ppfd_pkg::CfgCenterX:   r_ctr[0] <= i_cfg_data;
                    ppfd_pkg::CfgCenterY:   r_ctr[1] <= i_cfg_data;
                    ppfd_pkg::CfgCenterZ:   r_ctr[2] <= i_cfg_data;
                    ppfd_pkg::CfgDistLimit: r_lim    <= i_cfg_data[ppfd_pkg::LimitW-1:0];
                    default: ;
                endcase
            end

            // Drop the result once taken
            if (r_out_valid && i_m_tready) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (in_accept) begin
                        for (int i = 0; i < ppfd_pkg::Axes; i++) begin
                            r_pt[i]   <= in_pt[i];
                            r_prev[i] <= in_pt[i];
                            r_cmag[i] <= in_cmag[i];
                            r_mag[i]  <= in_shift ? in_dmag[i][31:1] : in_dmag[i][30:0];
                            r_neg[i]  <= in_dneg[i];
                            r_dir[i]  <= '0;
                        end
                        r_first <= i_s_tuser[0];
                        r_label <= i_s_tuser[ppfd_pkg::LabelW:1];
                        r_acc   <= '0;
                        r_cnt   <= '0;
                        r_state <= S_DIST;
                    end
                end

                S_DIST: begin
                    // Squares are registered into r_prod the cycle after their operand; sum them
                    r_prod <= sq_res;
                    if (r_cnt != '0) begin
                        r_acc <= r_acc + {2'b00, r_prod};
                    end
                    r_cnt <= r_cnt + CntW'(1);
                    if (r_cnt == CntW'(4)) begin
                        // r_prod holds the squared limit here
                        r_acc <= '0;
                        r_cnt <= '0;
                        if (r_acc > {2'b00, r_prod}) begin
                            r_state <= S_IDLE;
                        end else if (r_first) begin
                            r_state <= S_EMIT;
                        end else begin
                            r_state <= S_NORM;
                        end
                    end
                end

                S_NORM: begin
                    r_prod <= sq_res;
                    if (r_cnt != '0) begin
                        r_acc <= r_acc + {2'b00, r_prod};
                    end
                    r_cnt <= r_cnt + CntW'(1);
                    if (r_cnt == CntW'(3)) begin
                        r_v     <= 64'(r_acc) + r_prod;
                        r_root  <= '0;
                        r_bit   <= 64'h4000_0000_0000_0000;
                        r_state <= S_SQRT;
                    end
                end

                S_SQRT: begin
                    if (sqrt_ge) begin
                        r_v <= r_v - sqrt_sum[63:0];
                    end
                    r_root <= n_root;
                    r_bit  <= r_bit >> 2;
                    if (r_bit[0]) begin
                        // Zero-length segment keeps the zero direction
                        r_norm <= n_root[31:0];
                        r_axis <= '0;
                        r_rem  <= {1'b0, r_mag[0]};
                        r_q    <= '0;
                        r_cnt  <= '0;
                        r_state <= (n_root[31:0] == '0) ? S_EMIT : S_DIV;
                    end
                end

                S_DIV: begin
                    r_rem <= n_rem;
                    r_q   <= n_q[QW-2:0];
                    r_cnt <= r_cnt + CntW'(1);
                    if (r_cnt == CntW'(DIR_FRAC_BITS)) begin
                        r_dir[r_axis] <= n_dir;
                        r_cnt <= '0;
                        r_q   <= '0;
                        if (r_axis == 2'd2) begin
                            r_state <= S_EMIT;
                        end else begin
                            r_axis <= r_axis + 2'd1;
                            r_rem  <= {1'b0, r_mag[r_axis + 2'd1]};
                        end
                    end
                end

                S_EMIT: begin
                    // Hold until the output register is free
                    if (out_free) begin
                        r_out_valid <= 1'b1;
                        r_out_data  <= {r_dir[2], r_dir[1], r_dir[0],
                                        r_pt[2], r_pt[1], r_pt[0]};
                        r_out_user  <= r_label;
                        r_state     <= S_IDLE;
                    end
                end

                default: r_state <= S_IDLE;
            endcase
        end
    end

    // Busy in the cycle after taking a vertex
    `PPFD_ASSERT(a_busy_after_accept, in_accept |=> !o_s_tready)
    // Root search walks a single bit down the word
    `PPFD_ASSERT(a_sqrt_onehot, (r_state == S_SQRT) |-> $onehot(r_bit))
    // Divider runs only on a nonzero norm and keeps its remainder bounded
    `PPFD_ASSERT(a_div_bounds, (r_state == S_DIV) |-> (r_norm != '0 && r_rem <= r_norm))
    // A new result appears only out of the emit step
    `PPFD_ASSERT(a_result_source, $rose(o_m_tvalid) |-> $past(r_state == S_EMIT))
    // Reset leaves no result pending
    `PPFD_ASSERT_ALWAYS(a_reset_clears, !i_rst_n |=> !o_m_tvalid && o_s_tready)

endmodule
